// File: sv/terminal_key_sequence_decoder_defines.svh
// Assertion macros shared by the terminal key sequence decoder.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge of aclk outside reset.
`define TKSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tksd check failed");

// Next-cycle implication, checked at every rising edge of aclk outside reset.
`define TKSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tksd check failed");

`endif

// File: sv/tksd_pkg.sv
// Package with types, byte codes and event codes of the terminal key sequence decoder.
`timescale 1ns / 1ps

package tksd_pkg;

    // Decoder mode.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2,
        MODE_UTF8 = 2'd3
    } mode_t;

    // What the CSI parameter string holds so far.
    typedef enum logic [2:0] {
        PM_EMPTY   = 3'd0,
        PM_3       = 3'd1,
        PM_3SEMI   = 3'd2,
        PM_3SEMI5  = 3'd3,
        PM_OTHER   = 3'd4
    } pm_t;

    // What the last subparameter holds so far.
    typedef enum logic [1:0] {
        LS_EMPTY = 2'd0,
        LS_FIVE  = 2'd1,
        LS_OTHER = 2'd2
    } ls_t;

    // Event codes.
    localparam logic [3:0] EV_INSERT      = 4'd0;
    localparam logic [3:0] EV_NEWLINE     = 4'd1;
    localparam logic [3:0] EV_BACKSPACE   = 4'd2;
    localparam logic [3:0] EV_CTRL_BKSP   = 4'd3;
    localparam logic [3:0] EV_CTRL_W      = 4'd4;
    localparam logic [3:0] EV_TAB         = 4'd5;
    localparam logic [3:0] EV_UP          = 4'd6;
    localparam logic [3:0] EV_DOWN        = 4'd7;
    localparam logic [3:0] EV_RIGHT       = 4'd8;
    localparam logic [3:0] EV_LEFT        = 4'd9;
    localparam logic [3:0] EV_CTRL_RIGHT  = 4'd10;
    localparam logic [3:0] EV_CTRL_LEFT   = 4'd11;
    localparam logic [3:0] EV_HOME        = 4'd12;
    localparam logic [3:0] EV_END         = 4'd13;
    localparam logic [3:0] EV_DELETE      = 4'd14;
    localparam logic [3:0] EV_CTRL_DELETE = 4'd15;

    // Byte codes.
    localparam logic [7:0] CHR_NUL       = 8'h00;
    localparam logic [7:0] CHR_BS        = 8'h08;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_LF        = 8'h0A;
    localparam logic [7:0] CHR_ETB       = 8'h17;
    localparam logic [7:0] CHR_ESC       = 8'h1B;
    localparam logic [7:0] CHR_DEL       = 8'h7F;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_TILDE     = 8'h7E;
    localparam logic [7:0] CHR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHR_SEMI      = 8'h3B;
    localparam logic [7:0] CHR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHR_DIGIT_3   = 8'h33;
    localparam logic [7:0] CHR_DIGIT_5   = 8'h35;
    localparam logic [7:0] CHR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHR_A         = 8'h41;
    localparam logic [7:0] CHR_B         = 8'h42;
    localparam logic [7:0] CHR_C         = 8'h43;
    localparam logic [7:0] CHR_D         = 8'h44;
    localparam logic [7:0] CHR_F         = 8'h46;
    localparam logic [7:0] CHR_H         = 8'h48;
    localparam logic [7:0] CONT_LOW      = 8'h80;
    localparam logic [7:0] CONT_HIGH     = 8'hBF;

endpackage

// File: sv/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: byte in, key event out.
`timescale 1ns / 1ps
//
//  Channel | Ports                                         | Direction | Beat
//  --------+-----------------------------------------------+-----------+-------------------
//  input   | s_valid, s_ready, s_in_byte                   | in        | one terminal byte
//  result  | m_valid, m_ready, m_event_code,               | out       | one key event
//          | m_text_bytes, m_text_length                   |           |
//
//  Each byte is decoded in the cycle it is accepted, so one byte is taken every cycle while
//  s_ready is high; a single output register holds a finished event.
//  A byte that produces an event shows on the result channel in the cycle after its beat.
//  When the output register is full and m_ready is low, s_ready drops until it drains.
//  aresetn is synchronous and active low; it returns the decoder to idle and empties
//  the output register.

`include "terminal_key_sequence_decoder_defines.svh"

module terminal_key_sequence_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_code,
    output logic [31:0] m_text_bytes,
    output logic [2:0]  m_text_length
);

    // Decoder state. The UTF-8 fields are zero whenever the mode is idle.
    tksd_pkg::mode_t mode_reg, mode_next;
    tksd_pkg::pm_t   pm_reg, pm_next;
    tksd_pkg::ls_t   ls_reg, ls_next;
    logic [31:0]     coll_reg, coll_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [1:0]      rem_reg, rem_next;

    // Output register.
    logic            m_valid_reg;
    logic [3:0]      m_event_code_reg;
    logic [31:0]     m_text_bytes_reg;
    logic [2:0]      m_text_length_reg;

    // Event produced by the byte on the input port.
    logic            emit;
    logic [3:0]      ev_code;
    logic [31:0]     ev_bytes;
    logic [2:0]      ev_len;

    logic            accept;
    logic [7:0]      b;

    // Byte classes used by the mode logic and the datapath.
    logic            is_param;
    logic            is_print;
    logic            is_lead2;
    logic            is_lead3;
    logic            is_lead4;
    logic            is_lead;
    logic            utf8_bad;
    logic [31:0]     coll_merged;

    assign b      = s_in_byte;
    // The next byte is taken whenever the output register is empty or is draining now.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_param = ((b >= tksd_pkg::CHR_DIGIT_0) && (b <= tksd_pkg::CHR_DIGIT_9))
                      || (b == tksd_pkg::CHR_SEMI);
    assign is_print = (b >= tksd_pkg::CHR_SPACE) && (b <= tksd_pkg::CHR_TILDE);
    assign is_lead2 = (b[7:5] == 3'b110);
    assign is_lead3 = (b[7:4] == 4'b1110);
    assign is_lead4 = (b[7:3] == 5'b11110);
    assign is_lead  = is_lead2 || is_lead3 || is_lead4;

    // A continuation byte must lie in 0x80..0xBF; the count and remaining checks
    // keep the gather from ever writing outside the four byte lanes.
    assign utf8_bad = (b < tksd_pkg::CONT_LOW) || (b > tksd_pkg::CONT_HIGH)
                      || (cnt_reg == 3'd0) || (cnt_reg > 3'd3) || (rem_reg == 2'd0);

    // The new continuation byte goes into the lane given by the count so far.
    assign coll_merged = coll_reg | ({24'd0, b} << {cnt_reg[1:0], 3'b000});

    // Mode transitions.
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            tksd_pkg::MODE_IDLE: begin
                if (b == tksd_pkg::CHR_ESC) begin
                    mode_next = tksd_pkg::MODE_ESC;
                end else if (is_lead) begin
                    mode_next = tksd_pkg::MODE_UTF8;
                end
            end
            tksd_pkg::MODE_ESC: begin
                mode_next = (b == tksd_pkg::CHR_LBRACKET) ? tksd_pkg::MODE_CSI
                                                          : tksd_pkg::MODE_IDLE;
            end
            tksd_pkg::MODE_CSI: begin
                // NUL aborts, parameters stay, any other byte is the final byte.
                if ((b == tksd_pkg::CHR_NUL) || !is_param) begin
                    mode_next = tksd_pkg::MODE_IDLE;
                end
            end
            tksd_pkg::MODE_UTF8: begin
                if (utf8_bad || (rem_reg == 2'd1)) begin
                    mode_next = tksd_pkg::MODE_IDLE;
                end
            end
            default: mode_next = tksd_pkg::MODE_IDLE;
        endcase
    end

    // Datapath and event decode.
    always_comb begin
        pm_next   = pm_reg;
        ls_next   = ls_reg;
        coll_next = coll_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        emit      = 1'b0;
        ev_code   = tksd_pkg::EV_INSERT;
        ev_bytes  = 32'd0;
        ev_len    = 3'd0;

        unique case (mode_reg)
            tksd_pkg::MODE_IDLE: begin
                unique case (b)
                    tksd_pkg::CHR_NUL, tksd_pkg::CHR_ESC: begin
                        emit = 1'b0;
                    end
                    tksd_pkg::CHR_LF: begin
                        emit    = 1'b1;
                        ev_code = tksd_pkg::EV_NEWLINE;
                    end
                    tksd_pkg::CHR_DEL: begin
                        emit    = 1'b1;
                        ev_code = tksd_pkg::EV_BACKSPACE;
                    end
                    tksd_pkg::CHR_BS: begin
                        emit    = 1'b1;
                        ev_code = tksd_pkg::EV_CTRL_BKSP;
                    end
                    tksd_pkg::CHR_ETB: begin
                        emit    = 1'b1;
                        ev_code = tksd_pkg::EV_CTRL_W;
                    end
                    tksd_pkg::CHR_TAB: begin
                        emit    = 1'b1;
                        ev_code = tksd_pkg::EV_TAB;
                    end
                    default: begin
                        if (is_print) begin
                            emit     = 1'b1;
                            ev_code  = tksd_pkg::EV_INSERT;
                            ev_bytes = {24'd0, b};
                            ev_len   = 3'd1;
                        end else if (is_lead) begin
                            coll_next = {24'd0, b};
                            cnt_next  = 3'd1;
                            rem_next  = is_lead2 ? 2'd1 : (is_lead3 ? 2'd2 : 2'd3);
                        end
                    end
                endcase
            end
            tksd_pkg::MODE_ESC: begin
                if (b == tksd_pkg::CHR_LBRACKET) begin
                    pm_next = tksd_pkg::PM_EMPTY;
                    ls_next = tksd_pkg::LS_EMPTY;
                end
                coll_next = 32'd0;
                cnt_next  = 3'd0;
                rem_next  = 2'd0;
            end
            tksd_pkg::MODE_CSI: begin
                if ((b != tksd_pkg::CHR_NUL) && is_param) begin
                    // Parameter string tracking saturates to "anything else".
                    if ((pm_reg == tksd_pkg::PM_EMPTY) && (b == tksd_pkg::CHR_DIGIT_3)) begin
                        pm_next = tksd_pkg::PM_3;
                    end else if ((pm_reg == tksd_pkg::PM_3) && (b == tksd_pkg::CHR_SEMI)) begin
                        pm_next = tksd_pkg::PM_3SEMI;
                    end else if ((pm_reg == tksd_pkg::PM_3SEMI)
                                 && (b == tksd_pkg::CHR_DIGIT_5)) begin
                        pm_next = tksd_pkg::PM_3SEMI5;
                    end else begin
                        pm_next = tksd_pkg::PM_OTHER;
                    end
                    // A semicolon opens a fresh subparameter.
                    if (b == tksd_pkg::CHR_SEMI) begin
                        ls_next = tksd_pkg::LS_EMPTY;
                    end else if ((ls_reg == tksd_pkg::LS_EMPTY)
                                 && (b == tksd_pkg::CHR_DIGIT_5)) begin
                        ls_next = tksd_pkg::LS_FIVE;
                    end else begin
                        ls_next = tksd_pkg::LS_OTHER;
                    end
                end else begin
                    coll_next = 32'd0;
                    cnt_next  = 3'd0;
                    rem_next  = 2'd0;
                    if (b != tksd_pkg::CHR_NUL) begin
                        unique case (b)
                            tksd_pkg::CHR_TILDE: begin
                                if (pm_reg == tksd_pkg::PM_3SEMI5) begin
                                    emit    = 1'b1;
                                    ev_code = tksd_pkg::EV_CTRL_DELETE;
                                end else if (pm_reg == tksd_pkg::PM_3) begin
                                    emit    = 1'b1;
                                    ev_code = tksd_pkg::EV_DELETE;
                                end
                            end
                            tksd_pkg::CHR_A: begin
                                emit    = 1'b1;
                                ev_code = tksd_pkg::EV_UP;
                            end
                            tksd_pkg::CHR_B: begin
                                emit    = 1'b1;
                                ev_code = tksd_pkg::EV_DOWN;
                            end
                            tksd_pkg::CHR_C: begin
                                emit    = 1'b1;
                                ev_code = (ls_reg == tksd_pkg::LS_FIVE)
                                          ? tksd_pkg::EV_CTRL_RIGHT : tksd_pkg::EV_RIGHT;
                            end
                            tksd_pkg::CHR_D: begin
                                emit    = 1'b1;
                                ev_code = (ls_reg == tksd_pkg::LS_FIVE)
                                          ? tksd_pkg::EV_CTRL_LEFT : tksd_pkg::EV_LEFT;
                            end
                            tksd_pkg::CHR_F: begin
                                emit    = 1'b1;
                                ev_code = tksd_pkg::EV_END;
                            end
                            tksd_pkg::CHR_H: begin
                                emit    = 1'b1;
                                ev_code = tksd_pkg::EV_HOME;
                            end
                            default: emit = 1'b0;
                        endcase
                    end
                end
            end
            tksd_pkg::MODE_UTF8: begin
                if (utf8_bad) begin
                    coll_next = 32'd0;
                    cnt_next  = 3'd0;
                    rem_next  = 2'd0;
                end else if (rem_reg == 2'd1) begin
                    // Last continuation byte: hand out the whole character.
                    emit      = 1'b1;
                    ev_code   = tksd_pkg::EV_INSERT;
                    ev_bytes  = coll_merged;
                    ev_len    = cnt_reg + 3'd1;
                    coll_next = 32'd0;
                    cnt_next  = 3'd0;
                    rem_next  = 2'd0;
                end else begin
                    coll_next = coll_merged;
                    cnt_next  = cnt_reg + 3'd1;
                    rem_next  = rem_reg - 2'd1;
                end
            end
            default: emit = 1'b0;
        endcase
    end

    // Decoder state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tksd_pkg::MODE_IDLE;
            pm_reg   <= tksd_pkg::PM_EMPTY;
            ls_reg   <= tksd_pkg::LS_EMPTY;
            coll_reg <= 32'd0;
            cnt_reg  <= 3'd0;
            rem_reg  <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            pm_reg   <= pm_next;
            ls_reg   <= ls_next;
            coll_reg <= coll_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
        end
    end

    // Output register: loaded when an accepted byte yields an event, emptied on a beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_event_code_reg  <= ev_code;
            m_text_bytes_reg  <= ev_bytes;
            m_text_length_reg <= ev_len;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_code  = m_event_code_reg;
    assign m_text_bytes  = m_text_bytes_reg;
    assign m_text_length = m_text_length_reg;

    // A held event other than insert carries no text.
    `TKSD_ASSERT_NOW(a_no_text_on_keys, m_valid_reg && (m_event_code_reg != tksd_pkg::EV_INSERT), (m_text_length_reg == 3'd0) && (m_text_bytes_reg == 32'd0))
    // An insert event carries one to four bytes.
    `TKSD_ASSERT_NOW(a_insert_length, m_valid_reg && (m_event_code_reg == tksd_pkg::EV_INSERT), (m_text_length_reg != 3'd0) && (m_text_length_reg <= 3'd4))
    // While gathering UTF-8 the count and the bytes still due stay consistent.
    `TKSD_ASSERT_NOW(a_utf8_counts, mode_reg == tksd_pkg::MODE_UTF8, (rem_reg != 2'd0) && (cnt_reg != 3'd0) && ({1'b0, rem_reg} + cnt_reg <= 3'd4))
    // Outside a UTF-8 sequence nothing is left gathered.
    `TKSD_ASSERT_NEXT(a_idle_clean, accept && (mode_next != tksd_pkg::MODE_UTF8), (coll_reg == 32'd0) && (cnt_reg == 3'd0) && (rem_reg == 2'd0))

endmodule
